/* hdl/lrip_pkg.sv */
// Package: shared types, constants and the angle table for the range image projection.
`default_nettype none
package lrip_pkg;
  localparam int ROWS = 16;
  localparam int ROW_W = 4;
  localparam int COLUMNS = 2048;
  localparam int COL_W = 11;
  localparam int CELL_W = ROW_W + COL_W;
  localparam int POS_W = 20;
  localparam int RANGE_W = 20;
  localparam int STR_W = 16;
  localparam int RING_W = 16;
  localparam int RATE_W = 5;
  localparam int MINR_W = 16;
  localparam int CFG_W = 16;
  localparam int RAM_W = 32;
  localparam int RAM_SEL_W = 5;
  localparam int RAM_DEPTH = ROWS * COLUMNS / RAM_W;
  localparam int RAM_AW = CELL_W - RAM_SEL_W;
  localparam int CORDIC_STEPS = 18;
  localparam int STEP_W = 5;
  localparam int PRESCALE = 16;
  localparam int CX_W = 40;
  localparam int ANG_W = 22;
  localparam int ANG_FRAC = 20;
  localparam int QUARTER_TURN = 262144;
  localparam int COL_SHIFT = ANG_FRAC - COL_W;
  localparam int SUM_W = 40;
  localparam int MSQ_W = 2 * MINR_W;
  localparam int MUL_W = POS_W + 1;

  localparam logic [2:0] REASON_KEPT = 3'd0;
  localparam logic [2:0] REASON_RING_RANGE = 3'd1;
  localparam logic [2:0] REASON_RING_SKIP = 3'd2;
  localparam logic [2:0] REASON_TOO_NEAR = 3'd3;
  localparam logic [2:0] REASON_CELL_TAKEN = 3'd4;

  localparam logic CFG_RATE = 1'b0;
  localparam logic CFG_MINR = 1'b1;

  typedef struct packed {
    logic frame_start;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [POS_W-1:0] pos_z;
    logic [RING_W-1:0] ring_number;
    logic [STR_W-1:0] strength;
  } in_t;

  typedef struct packed {
    logic accepted;
    logic [2:0] reject_reason;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] column;
    logic [CELL_W-1:0] cell_index;
    logic [RANGE_W-1:0] range_out;
    logic [STR_W-1:0] strength_out;
  } out_t;

  typedef struct packed {
    logic near;
    logic [RANGE_W-1:0] range;
  } mag_res_t;

  function automatic logic signed [ANG_W-1:0] angle_entry(input logic [STEP_W-1:0] i);
    logic signed [ANG_W-1:0] v;
    case (i)
      5'd0: v = 22'sd131072;
      5'd1: v = 22'sd77376;
      5'd2: v = 22'sd40884;
      5'd3: v = 22'sd20753;
      5'd4: v = 22'sd10417;
      5'd5: v = 22'sd5213;
      5'd6: v = 22'sd2607;
      5'd7: v = 22'sd1304;
      5'd8: v = 22'sd652;
      5'd9: v = 22'sd326;
      5'd10: v = 22'sd163;
      5'd11: v = 22'sd81;
      5'd12: v = 22'sd41;
      5'd13: v = 22'sd20;
      5'd14: v = 22'sd10;
      5'd15: v = 22'sd5;
      5'd16: v = 22'sd3;
      5'd17: v = 22'sd1;
      default: v = '0;
    endcase
    return v;
  endfunction
endpackage
`default_nettype wire

/* hdl/lidar_range_image_projection.sv */
// Top level: request sequencer, column mapping and occupancy store.
// A request whose ring is kept passes the ring-skip remainder (one subtraction per
// cycle), the magnitude unit (four squarings, then one square-root bit per cycle),
// which the 18-step angle unit runs beside, and the occupancy read and update.
// Rings rejected by range or skip go straight to the result without the units.
// The occupancy store is a 1024 x 32 memory; after reset and for each request
// with frame_start set, a clearing pass writes one row per cycle through every
// row before work goes on.
// A finished result waits in the output register while the next request is taken.
`default_nettype none
module lidar_range_image_projection import lrip_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire in_t              in_data,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output out_t                  out_data,
  input  wire logic             cfg_write,
  input  wire logic             cfg_index,
  input  wire logic [CFG_W-1:0] cfg_data
);
  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_RING, ST_SKIP, ST_CALC, ST_READ, ST_LOOK, ST_FIN
  } state_t;
  state_t state;
  in_t req;
  logic pend;
  logic [RAM_AW-1:0] clr_cnt;
  logic [RATE_W-1:0] rate, rate_eff, ring_rem;
  logic [MINR_W-1:0] min_range;
  logic unit_start, ang_ok, mag_ok, ang_done, mag_done;
  logic signed [ANG_W-1:0] angle;
  mag_res_t mres;
  logic [2:0] reason;
  logic [ROW_W-1:0] row;
  logic [COL_W-1:0] col;
  logic [RANGE_W-1:0] range_v;
  logic signed [ANG_W:0] dang;
  logic [ANG_W:0] dmag;
  logic [ANG_W-COL_SHIFT:0] rq;
  logic signed [COL_W+3:0] cval, cwrap;
  logic [CELL_W-1:0] cell_idx;
  logic ram_we;
  logic [RAM_AW-1:0] ram_waddr;
  logic [RAM_W-1:0] ram_wdata, ram_rdata, mask;

  assign in_ready = (state == ST_IDLE);
  assign rate_eff = (rate == '0) ? RATE_W'(1) : rate;
  assign cell_idx = {row, col};
  assign mask = RAM_W'(1) << cell_idx[RAM_SEL_W-1:0];

  always_comb begin
    dang = {angle[ANG_W-1], angle} - (ANG_W+1)'(QUARTER_TURN);
    dmag = dang[ANG_W] ? (ANG_W+1)'(-dang) : (ANG_W+1)'(dang);
    rq = (ANG_W-COL_SHIFT+1)'((dmag + (ANG_W+1)'(1 << (COL_SHIFT-1))) >> COL_SHIFT);
    if (dang[ANG_W]) begin
      cval = (COL_W+4)'(COLUMNS/2) + (COL_W+4)'(rq);
    end else begin
      cval = (COL_W+4)'(COLUMNS/2) - (COL_W+4)'(rq);
    end
    if (cval >= (COL_W+4)'(COLUMNS)) begin
      cwrap = cval - (COL_W+4)'(COLUMNS);
    end else if (cval < 0) begin
      cwrap = cval + (COL_W+4)'(COLUMNS);
    end else begin
      cwrap = cval;
    end
  end

  always_comb begin
    ram_we = 1'b0;
    ram_waddr = cell_idx[CELL_W-1:RAM_SEL_W];
    ram_wdata = ram_rdata | mask;
    if (state == ST_CLEAR) begin
      ram_we = 1'b1;
      ram_waddr = clr_cnt;
      ram_wdata = '0;
    end else if (state == ST_LOOK && !mres.near && (ram_rdata & mask) == '0) begin
      ram_we = 1'b1;
    end
  end

  lrip_ram #(.WIDTH(RAM_W), .DEPTH(RAM_DEPTH)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (cell_idx[CELL_W-1:RAM_SEL_W]),
    .rdata (ram_rdata)
  );

  lrip_cordic u_cordic (
    .clk   (clk),
    .rst   (rst),
    .start (unit_start),
    .pos_x (req.pos_x),
    .pos_y (req.pos_y),
    .done  (ang_done),
    .angle (angle)
  );

  lrip_mag u_mag (
    .clk       (clk),
    .rst       (rst),
    .start     (unit_start),
    .pos_x     (req.pos_x),
    .pos_y     (req.pos_y),
    .pos_z     (req.pos_z),
    .min_range (min_range),
    .done      (mag_done),
    .res       (mres)
  );

  always_ff @(posedge clk) begin
    if (cfg_write && !rst) begin
      case (cfg_index)
        CFG_RATE: rate <= cfg_data[RATE_W-1:0];
        CFG_MINR: min_range <= cfg_data[MINR_W-1:0];
        default: ;
      endcase
    end
    if (rst) begin
      rate <= RATE_W'(1);
      min_range <= MINR_W'(256);
      state <= ST_CLEAR;
      clr_cnt <= '0;
      pend <= 1'b0;
      out_valid <= 1'b0;
      unit_start <= 1'b0;
    end else begin
      unit_start <= (state == ST_SKIP) && (ring_rem == '0);
      if (out_valid && out_ready && state != ST_FIN) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == '1) begin
            state <= pend ? ST_RING : ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_valid) begin
            req <= in_data;
            row <= '0;
            col <= '0;
            range_v <= '0;
            pend <= 1'b1;
            clr_cnt <= '0;
            state <= in_data.frame_start ? ST_CLEAR : ST_RING;
          end
        end
        ST_RING: begin
          if (req.ring_number[RING_W-1:ROW_W] != '0) begin
            reason <= REASON_RING_RANGE;
            state <= ST_FIN;
          end else begin
            ring_rem <= RATE_W'(req.ring_number[ROW_W-1:0]);
            state <= ST_SKIP;
          end
        end
        ST_SKIP: begin
          if (ring_rem >= rate_eff) begin
            ring_rem <= ring_rem - rate_eff;
          end else if (ring_rem != '0) begin
            reason <= REASON_RING_SKIP;
            state <= ST_FIN;
          end else begin
            ang_ok <= 1'b0;
            mag_ok <= 1'b0;
            state <= ST_CALC;
          end
        end
        ST_CALC: begin
          if (ang_done) begin
            ang_ok <= 1'b1;
          end
          if (mag_done) begin
            mag_ok <= 1'b1;
          end
          if (ang_ok && mag_ok) begin
            row <= req.ring_number[ROW_W-1:0];
            col <= cwrap[COL_W-1:0];
            range_v <= mres.range;
            state <= ST_READ;
          end
        end
        ST_READ: begin
          state <= ST_LOOK;
        end
        ST_LOOK: begin
          if (mres.near) begin
            reason <= REASON_TOO_NEAR;
          end else if ((ram_rdata & mask) != '0) begin
            reason <= REASON_CELL_TAKEN;
          end else begin
            reason <= REASON_KEPT;
          end
          state <= ST_FIN;
        end
        ST_FIN: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            out_data.accepted <= (reason == REASON_KEPT);
            out_data.reject_reason <= reason;
            out_data.row <= row;
            out_data.column <= col;
            out_data.cell_index <= cell_idx;
            out_data.range_out <= range_v;
            out_data.strength_out <= req.strength;
            pend <= 1'b0;
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

/* hdl/lrip_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module lrip_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

/* hdl/lrip_cordic.sv */
// Iterative vectoring CORDIC giving the horizontal angle in 2^-20 turn.
`default_nettype none
module lrip_cordic import lrip_pkg::*; (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     start,
  input  wire logic signed [POS_W-1:0]  pos_x,
  input  wire logic signed [POS_W-1:0]  pos_y,
  output logic                          done,
  output logic signed [ANG_W-1:0]       angle
);
  typedef enum logic [1:0] {S_IDLE, S_RUN, S_DONE} state_t;
  state_t state;
  logic signed [CX_W-1:0] cx, cy, cx0, cy0, dx, dy;
  logic signed [ANG_W-1:0] z;
  logic [STEP_W-1:0] cnt;
  logic is_zero;

  assign cx0 = {{(CX_W-POS_W-PRESCALE){pos_y[POS_W-1]}}, pos_y, {PRESCALE{1'b0}}};
  assign cy0 = {{(CX_W-POS_W-PRESCALE){pos_x[POS_W-1]}}, pos_x, {PRESCALE{1'b0}}};
  assign dx = cy >>> cnt;
  assign dy = cx >>> cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            is_zero <= (pos_x == '0) && (pos_y == '0);
            cnt <= '0;
            if (pos_y[POS_W-1]) begin
              if (!pos_x[POS_W-1]) begin
                cx <= cy0;
                cy <= -cx0;
                z <= ANG_W'(QUARTER_TURN);
              end else begin
                cx <= -cy0;
                cy <= cx0;
                z <= -ANG_W'(QUARTER_TURN);
              end
            end else begin
              cx <= cx0;
              cy <= cy0;
              z <= '0;
            end
            state <= S_RUN;
          end
        end
        S_RUN: begin
          if (!cy[CX_W-1]) begin
            cx <= cx + dx;
            cy <= cy - dy;
            z <= z + angle_entry(cnt);
          end else begin
            cx <= cx - dx;
            cy <= cy + dy;
            z <= z - angle_entry(cnt);
          end
          if (cnt == STEP_W'(CORDIC_STEPS - 1)) begin
            state <= S_DONE;
          end
          cnt <= cnt + 1'b1;
        end
        S_DONE: begin
          angle <= is_zero ? '0 : z;
          done <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

/* hdl/lrip_mag.sv */
// Iterative 3-D magnitude: shared squarer, bitwise square root, near check.
`default_nettype none
module lrip_mag import lrip_pkg::*; (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    start,
  input  wire logic signed [POS_W-1:0] pos_x,
  input  wire logic signed [POS_W-1:0] pos_y,
  input  wire logic signed [POS_W-1:0] pos_z,
  input  wire logic [MINR_W-1:0]       min_range,
  output logic                         done,
  output mag_res_t                     res
);
  localparam int REM_W = RANGE_W + 4;
  typedef enum logic [1:0] {S_IDLE, S_MUL, S_ROOT, S_DONE} state_t;
  state_t state;
  logic [STEP_W-1:0] cnt;
  logic signed [MUL_W-1:0] opnd;
  logic signed [2*MUL_W-1:0] prod;
  logic [SUM_W-1:0] sum, shreg;
  logic [MSQ_W-1:0] msq;
  logic [REM_W-1:0] rem, remn, trial;
  logic [RANGE_W-1:0] root;

  always_comb begin
    case (cnt)
      5'd0: opnd = MUL_W'(pos_x);
      5'd1: opnd = MUL_W'(pos_y);
      5'd2: opnd = MUL_W'(pos_z);
      default: opnd = {{(MUL_W-MINR_W){1'b0}}, min_range};
    endcase
  end

  assign remn = {rem[REM_W-3:0], shreg[SUM_W-1 -: 2]};
  assign trial = {2'b00, root, 2'b01};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            cnt <= '0;
            sum <= '0;
            state <= S_MUL;
          end
        end
        S_MUL: begin
          prod <= opnd * opnd;
          if (cnt != '0 && cnt != 5'd4) begin
            sum <= sum + prod[SUM_W-1:0];
          end
          if (cnt == 5'd4) begin
            msq <= prod[MSQ_W-1:0];
            shreg <= sum;
            rem <= '0;
            root <= '0;
            cnt <= '0;
            state <= S_ROOT;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_ROOT: begin
          if (remn >= trial) begin
            rem <= remn - trial;
            root <= {root[RANGE_W-2:0], 1'b1};
          end else begin
            rem <= remn;
            root <= {root[RANGE_W-2:0], 1'b0};
          end
          shreg <= {shreg[SUM_W-3:0], 2'b00};
          if (cnt == 5'(RANGE_W - 1)) begin
            state <= S_DONE;
          end
          cnt <= cnt + 1'b1;
        end
        S_DONE: begin
          res.range <= (rem > REM_W'(root) && root != '1) ? root + 1'b1 : root;
          res.near <= sum < SUM_W'(msq);
          done <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

/* hdl/lrip_checker.sv */
// Port checker for the range image projection, bound to the top level.
`default_nettype none
module lrip_checker import lrip_pkg::*; (
  input wire logic             clk,
  input wire logic             rst,
  input wire logic             in_valid,
  input wire logic             in_ready,
  input wire logic             out_valid,
  input wire logic             out_ready,
  input wire out_t             out_data
);
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result dropped or changed while stalled");

  a_accept_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.accepted == (out_data.reject_reason == REASON_KEPT))
    else $error("accepted flag disagrees with reason");

  a_cell: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.cell_index == {out_data.row, out_data.column})
    else $error("cell index mismatch");

  a_early: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.reject_reason == REASON_RING_RANGE ||
                  out_data.reject_reason == REASON_RING_SKIP)
    |-> out_data.range_out == '0 && out_data.column == '0 && out_data.row == '0)
    else $error("early reject carries data");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second request taken while busy");
endmodule

bind lidar_range_image_projection lrip_checker u_lrip_checker (.*);
`default_nettype wire
